### rtl/spq_pkg.sv
`default_nettype none
package spq_pkg;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [15:0] entry_id;
      logic [3:0]  entry_severity;
      logic [15:0] entry_stamp;
   } spq_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] head_id;
      logic [3:0]  head_severity;
      logic [15:0] head_stamp;
      logic [4:0]  occupancy;
   } spq_rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  severity;
      logic [15:0] stamp;
   } spq_entry_type;

   // shift command broadcast to every cell
   typedef struct packed {
      logic enq;
      logic deq;
   } spq_ctrl_type;

endpackage
`default_nettype wire

### rtl/spq_cell.sv
`default_nettype none
module spq_cell (
   input  wire                   clock,
   input  spq_pkg::spq_ctrl_type ctrl,
   input  spq_pkg::spq_entry_type new_entry,
   input  wire                   occupied,
   input  spq_pkg::spq_entry_type left_entry,
   input  wire                   left_insert,
   input  spq_pkg::spq_entry_type right_entry,
   output spq_pkg::spq_entry_type entry,
   output logic                  insert
);
   import spq_pkg::*;

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // new entry goes ahead of this cell when it strictly wins, or when the cell is free
   always_comb begin
      insert = !occupied ||
               (new_entry.severity > entry_ff.severity) ||
               ((new_entry.severity == entry_ff.severity) &&
                (new_entry.stamp < entry_ff.stamp));
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq && insert) begin
         // boundary cell takes the new entry, cells behind it shift toward the tail
         entry_in = left_insert ? left_entry : new_entry;
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

### rtl/sorted_priority_queue_top.sv
`default_nettype none
// Sorted priority queue built as a chain of shift cells.
//
// Requests arrive on req_valid / req_stall / req_data. An enqueue request
// places its entry in order (higher severity first, then smaller stamp,
// ties behind entries already held); a dequeue request removes the head.
// Every request yields exactly one response on rsp_valid / rsp_stall /
// rsp_data carrying status, the dequeued head (zero otherwise) and the
// occupancy after the request.
//
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one request per cycle while req_stall is low; every cell compares
// against the new entry in parallel and shifts its neighbor's data.
// A held response stalls the request channel only while rsp_stall is high;
// a response taken in the same cycle frees the output register at once.
//
// Reset (synchronous, active high) clears the entry count and the response
// valid; cell contents are left as they are and are never read when free.
module sorted_priority_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  spq_pkg::spq_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output spq_pkg::spq_rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   spq_rsp_type   rsp_data_ff;
   spq_rsp_type   rsp_data_in;

   logic          accept;
   logic          full;
   logic          empty;
   spq_ctrl_type  ctrl;
   spq_entry_type new_entry;

   spq_entry_type cell_entry  [QUEUE_DEPTH];
   logic          cell_insert [QUEUE_DEPTH];

   // hold new requests only while a response waits and is not taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   assign new_entry.id       = req_data.entry_id;
   assign new_entry.severity = req_data.entry_severity;
   assign new_entry.stamp    = req_data.entry_stamp;

   // drop rejected requests: no shift when full on enqueue or empty on dequeue
   assign ctrl.enq = accept && (req_data.kind == KIND_ENQUEUE) && !full;
   assign ctrl.deq = accept && (req_data.kind == KIND_DEQUEUE) && !empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_entry_type left_entry;
      spq_entry_type right_entry;
      logic          left_insert;

      if (i == 0) begin : g_head
         assign left_entry  = new_entry;
         assign left_insert = 1'b0;
      end else begin : g_body
         assign left_entry  = cell_entry[i-1];
         assign left_insert = cell_insert[i-1];
      end

      // tail cell holds its own contents on a dequeue
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .occupied    (CW'(i) < count_ff),
         .left_entry  (left_entry),
         .left_insert (left_insert),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .insert      (cell_insert[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.enq) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.deq) begin
         count_in = count_ff - CW'(1);
      end
   end

   // build the response from the head cell as it stands before the shift
   always_comb begin
      rsp_data_in               = rsp_data_ff;
      rsp_valid_in              = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = STATUS_DONE;
         rsp_data_in.head_id       = '0;
         rsp_data_in.head_severity = '0;
         rsp_data_in.head_stamp    = '0;
         rsp_data_in.occupancy     = 5'(count_in);
         if (req_data.kind == KIND_ENQUEUE) begin
            if (full) begin
               rsp_data_in.status = STATUS_FULL;
            end
         end else if (empty) begin
            rsp_data_in.status = STATUS_EMPTY;
         end else begin
            rsp_data_in.head_id       = cell_entry[0].id;
            rsp_data_in.head_severity = cell_entry[0].severity;
            rsp_data_in.head_stamp    = cell_entry[0].stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_REQUESTS = 400;
   localparam int BURST_LENGTH = 24;

   // Shadow copy of the sorted queue. Each accepted request is applied here
   // and yields the response the block must return for it.
   class order_tracker;
      spq_entry_type held_entries[QUEUE_DEPTH];
      int            held_count = 0;
      spq_rsp_type   awaited_rsp[$];
      int            failures = 0;

      // true when the new entry must be served strictly ahead of cell c
      function bit outranks(spq_entry_type e, spq_entry_type c);
         return (e.severity > c.severity) ||
                (e.severity == c.severity && e.stamp < c.stamp);
      endfunction

      function void note_request(spq_req_type r);
         spq_rsp_type   rsp;
         spq_entry_type e;
         int            pos;
         rsp = '0;
         e.id = r.entry_id;
         e.severity = r.entry_severity;
         e.stamp = r.entry_stamp;
         if (r.kind == KIND_ENQUEUE) begin
            if (held_count >= QUEUE_DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               pos = held_count;
               for (int i = 0; i < held_count; i++) begin
                  if (outranks(e, held_entries[i])) begin
                     pos = i;
                     break;
                  end
               end
               for (int i = held_count; i > pos; i--)
                  held_entries[i] = held_entries[i-1];
               held_entries[pos] = e;
               held_count++;
               rsp.status = STATUS_DONE;
            end
         end else begin
            if (held_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               rsp.status = STATUS_DONE;
               rsp.head_id = held_entries[0].id;
               rsp.head_severity = held_entries[0].severity;
               rsp.head_stamp = held_entries[0].stamp;
               for (int i = 1; i < held_count; i++)
                  held_entries[i-1] = held_entries[i];
               held_count--;
            end
         end
         rsp.occupancy = held_count[4:0];
         awaited_rsp.push_back(rsp);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(spq_rsp_type got);
         spq_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $error("response with no request outstanding: %0h", got);
            failures++;
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("head_id", 32'(want.head_id), 32'(got.head_id));
         compare_field("head_severity", 32'(want.head_severity),
                       32'(got.head_severity));
         compare_field("head_stamp", 32'(want.head_stamp), 32'(got.head_stamp));
         compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
      endfunction

      function int outstanding();
         return awaited_rsp.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   spq_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   spq_rsp_type rsp_data;

   // idle rates in percent, changed between phases of the run
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   order_tracker tracker = new;

   sorted_priority_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Receiver: stall at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Monitor: sample both handshakes at the edge. Note the request first so
   // its expectation lands behind any older one still waiting.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_request(req_data);
         if (rsp_valid && !rsp_stall)
            tracker.check_response(rsp_data);
      end
   end

   // Hand one request to the block: idle for a random while, raise valid,
   // then hold the payload until an edge sees stall low.
   task automatic send_request(input spq_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_fields(input logic k, input logic [15:0] id,
                              input logic [3:0] sev, input logic [15:0] stamp);
      spq_req_type r;
      r.kind = k;
      r.entry_id = id;
      r.entry_severity = sev;
      r.entry_stamp = stamp;
      send_request(r);
   endtask

   // Draw a request; keep severities narrow most of the time and stamps narrow
   // half the time so that ties on both keys show up often.
   function automatic spq_req_type random_request(int enq_pct);
      spq_req_type r;
      r.kind = ($urandom_range(99) < enq_pct) ? KIND_ENQUEUE : KIND_DEQUEUE;
      r.entry_id = 16'($urandom());
      r.entry_severity = ($urandom_range(99) < 60) ? 4'($urandom_range(3))
                                                   : 4'($urandom_range(15));
      r.entry_stamp = ($urandom_range(99) < 50) ? 16'($urandom_range(7))
                                                : 16'($urandom());
      return r;
   endfunction

   initial begin
      int enq_pct;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: dequeue on an empty queue, extreme field values,
      // ties on severity and stamp, filling to the brim, enqueue on full.
      send_fields(KIND_DEQUEUE, 16'h0000, 4'h0, 16'h0000);
      send_fields(KIND_ENQUEUE, 16'hffff, 4'h0, 16'hffff);
      send_fields(KIND_ENQUEUE, 16'h0000, 4'hf, 16'h0000);
      send_fields(KIND_ENQUEUE, 16'h0001, 4'hf, 16'h0000);
      send_fields(KIND_ENQUEUE, 16'h0002, 4'hf, 16'hffff);
      send_fields(KIND_ENQUEUE, 16'h0003, 4'h0, 16'h0000);
      send_fields(KIND_ENQUEUE, 16'h0004, 4'h0, 16'hffff);
      send_fields(KIND_ENQUEUE, 16'haaaa, 4'h5, 16'h5555);
      send_fields(KIND_ENQUEUE, 16'h5555, 4'ha, 16'haaaa);
      for (int i = 0; i < 8; i++)
         send_fields(KIND_ENQUEUE, 16'h0100 + 16'(i), 4'h7, 16'(i % 3));
      send_fields(KIND_ENQUEUE, 16'hffff, 4'hf, 16'h0000);
      repeat (3) send_fields(KIND_DEQUEUE, 16'hffff, 4'hf, 16'hffff);

      // Random part in three phases of idling. Bursts lean toward enqueue
      // or dequeue so that the queue swings between full and empty.
      enq_pct = 50;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 0) begin
            send_idle_pct = 33;
            rsp_stall_pct = 74;
         end else if (n == RANDOM_REQUESTS / 3) begin
            send_idle_pct = 74;
            rsp_stall_pct = 33;
         end else if (n == 2 * RANDOM_REQUESTS / 3) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         if (n % BURST_LENGTH == 0) begin
            case ($urandom_range(2))
               0: begin
                  enq_pct = 85;
               end
               1: begin
                  enq_pct = 15;
               end
               default: begin
                  enq_pct = 50;
               end
            endcase
         end
         send_request(random_request(enq_pct));
      end
      req_valid <= 1'b0;

      // Drain: wait for every response, then a few more edges to catch
      // anything spurious.
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
